### rtl/wrv_pkg.sv
package wrv_pkg;

	localparam int CNT_W   = 32;
	localparam int DATA_W  = 32;
	localparam int M2_W    = 64;
	localparam int VAR_W   = 63;
	localparam int DIVR_W  = 32;

	// The divider retires two quotient bits per cycle.
	localparam int DIV_SHORT_CYC = 16;
	localparam int DIV_LONG_CYC  = 32;
	localparam int DIV_CNT_W     = $clog2(DIV_LONG_CYC);

	localparam logic [CNT_W-1:0] COUNT_MAX = '1;
	localparam logic [VAR_W-1:0] VAR_MAX   = '1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_MDIV,
		ST_MEAN,
		ST_MUL,
		ST_ACC,
		ST_VSTART,
		ST_VDIV,
		ST_DONE
	} wrv_state_t;

	typedef struct packed {
		logic capture;
		logic do_clear;
		logic do_first;
		logic do_push;
		logic mean_upd;
		logic mul;
		logic acc;
		logic vdiv_start;
		logic set_drop;
		logic out_load;
	} wrv_cmd_t;

	typedef struct packed {
		logic is_clear;
		logic is_full;
		logic is_first;
		logic cnt_gt1;
		logic div_busy;
	} wrv_sts_t;

endpackage

### rtl/welford_running_variance.sv
// Channel | Signals                                   | Direction | Item
// --------+-------------------------------------------+-----------+---------------------------
// in      | in_valid, in_ready, action, sample        | into      | one clear or one push
// out     | out_valid, out_ready, entry_count,        | out of    | statistics after the item
//         | running_mean, sample_variance, dropped    |           |
//
// The block handles one item at a time. A push that is neither the first sample nor a
// dropped one passes after acceptance through a decode step, the shared divider for the
// mean step, a mean update, a multiply, an accumulate, a start step, the same divider
// for the variance and a load step. A clear or a first push goes from decode straight
// to the load step; a dropped push goes from decode to the start step, as the variance
// is recomputed. The next item can be taken in the cycle after the result is loaded.
// Reset is asynchronous and active low; it empties the accumulator and the output valid flag.
// The next item is accepted while a result still waits in the output register; the block
// stalls only when a new result is ready and the previous one has not yet been taken.
module welford_running_variance
	import wrv_pkg::*;
#(
	parameter int SAMPLE_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              action,
	input  logic [DATA_W-1:0] sample,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [CNT_W-1:0]  entry_count,
	output logic [DATA_W-1:0] running_mean,
	output logic [VAR_W-1:0]  sample_variance,
	output logic              dropped
);

	// The controller sequences each item; the datapath holds the count, the mean and the
	// sum of squared deviations, together with the shared iterative divider.
	wrv_cmd_t cmd;
	wrv_sts_t sts;

	wrv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The sample is sign-extended from bit SAMPLE_BITS-1; the mean is kept at that width
	// because each step moves it towards the sample and never beyond the sample range.
	wrv_dp #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.action          (action),
		.sample          (sample),
		.entry_count     (entry_count),
		.running_mean    (running_mean),
		.sample_variance (sample_variance),
		.dropped         (dropped)
	);

endmodule

### rtl/wrv_div.sv
module wrv_div
	import wrv_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              long_run,
	input  logic [M2_W-1:0]   dividend,
	input  logic [DIVR_W-1:0] divisor,
	output logic              busy,
	output logic [M2_W-1:0]   quotient
);

	logic                 busy_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIVR_W-1:0]    rem_q;
	logic [M2_W-1:0]      qd_q;
	logic [DIVR_W-1:0]    div_q;
	logic [DIVR_W-1:0]    rem_mid;
	logic [M2_W-1:0]      qd_mid;
	logic [DIVR_W-1:0]    rem_nxt;
	logic [M2_W-1:0]      qd_nxt;

	// One restoring step: shift in the next dividend bit, subtract if it fits.
	function automatic logic [DIVR_W+M2_W-1:0] div_step(
		input logic [DIVR_W-1:0] r,
		input logic [M2_W-1:0]   qd,
		input logic [DIVR_W-1:0] d
	);
		logic [DIVR_W:0]   r1;
		logic [DIVR_W:0]   diff;
		logic              ge;
		logic [DIVR_W-1:0] rn;
		r1   = {r, qd[M2_W-1]};
		diff = r1 - {1'b0, d};
		ge   = (r1 >= {1'b0, d});
		rn   = ge ? diff[DIVR_W-1:0] : r1[DIVR_W-1:0];
		return {rn, qd[M2_W-2:0], ge};
	endfunction

	always_comb begin
		{rem_mid, qd_mid} = div_step(rem_q, qd_q, div_q);
		{rem_nxt, qd_nxt} = div_step(rem_mid, qd_mid, div_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= long_run ? DIV_CNT_W'(DIV_LONG_CYC - 1) : DIV_CNT_W'(DIV_SHORT_CYC - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= divisor;
			qd_q  <= long_run ? dividend : {dividend[DIVR_W-1:0], {(M2_W-DIVR_W){1'b0}}};
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			qd_q  <= qd_nxt;
		end
	end

	assign busy     = busy_q;
	assign quotient = qd_q;

endmodule

### rtl/wrv_ctrl.sv
module wrv_ctrl
	import wrv_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  wrv_sts_t sts,
	output wrv_cmd_t cmd
);

	wrv_state_t state_q;
	wrv_state_t state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				priority if (sts.is_clear) begin
					state_d = ST_DONE;
				end else if (sts.is_full) begin
					state_d = ST_VSTART;
				end else if (sts.is_first) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_MDIV;
				end
			end
			ST_MDIV: begin
				if (!sts.div_busy) begin
					state_d = ST_MEAN;
				end
			end
			ST_MEAN:   state_d = ST_MUL;
			ST_MUL:    state_d = ST_ACC;
			ST_ACC:    state_d = ST_VSTART;
			ST_VSTART: state_d = sts.cnt_gt1 ? ST_VDIV : ST_DONE;
			ST_VDIV: begin
				if (!sts.div_busy) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_DECODE: begin
				priority if (sts.is_clear) begin
					cmd.do_clear = 1'b1;
				end else if (sts.is_full) begin
					cmd.set_drop = 1'b1;
				end else if (sts.is_first) begin
					cmd.do_first = 1'b1;
				end else begin
					cmd.do_push = 1'b1;
				end
			end
			ST_MEAN:   cmd.mean_upd   = 1'b1;
			ST_MUL:    cmd.mul        = 1'b1;
			ST_ACC:    cmd.acc        = 1'b1;
			ST_VSTART: cmd.vdiv_start = sts.cnt_gt1;
			ST_DONE:   cmd.out_load   = out_free;
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

### rtl/wrv_dp.sv
module wrv_dp
	import wrv_pkg::*;
#(
	parameter int SAMPLE_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  wrv_cmd_t          cmd,
	output wrv_sts_t          sts,
	input  logic              action,
	input  logic [DATA_W-1:0] sample,
	output logic [CNT_W-1:0]  entry_count,
	output logic [DATA_W-1:0] running_mean,
	output logic [VAR_W-1:0]  sample_variance,
	output logic              dropped
);

	localparam int SB = SAMPLE_BITS;

	// Architectural state.
	logic [CNT_W-1:0]     count_q;
	logic signed [SB-1:0] mean_q;
	logic [M2_W-1:0]      m2_q;

	// Working registers for one item.
	logic                 act_q;
	logic signed [SB-1:0] x_q;
	logic                 d_neg_q;
	logic [SB-1:0]        d_mag_q;
	logic [2*SB-1:0]      prod_q;
	logic                 drop_q;

	// Result register.
	logic [CNT_W-1:0]     cnt_out_q;
	logic [DATA_W-1:0]    mean_out_q;
	logic [VAR_W-1:0]     var_out_q;
	logic                 drop_out_q;

	logic signed [SB:0]   d_full;
	logic [SB:0]          d_abs;
	logic signed [SB:0]   e_full;
	logic [SB:0]          e_abs;
	logic [SB:0]          q_mag;
	logic [SB:0]          q_signed;
	logic [SB:0]          mean_sum;
	logic [M2_W:0]        m2_sum;
	logic                 div_start;
	logic                 div_long;
	logic [M2_W-1:0]      div_dividend;
	logic [DIVR_W-1:0]    div_divisor;
	logic                 div_busy;
	logic [M2_W-1:0]      div_quot;
	logic [VAR_W-1:0]     var_val;

	always_comb begin
		d_full   = {x_q[SB-1], x_q} - {mean_q[SB-1], mean_q};
		d_abs    = d_full[SB] ? -d_full : d_full;
		e_full   = {x_q[SB-1], x_q} - {mean_q[SB-1], mean_q};
		e_abs    = e_full[SB] ? -e_full : e_full;
		q_mag    = {1'b0, div_quot[SB-1:0]};
		q_signed = d_neg_q ? -q_mag : q_mag;
		mean_sum = {mean_q[SB-1], mean_q} + q_signed;
		m2_sum   = {1'b0, m2_q} + (M2_W+1)'(prod_q);
	end

	// The same divider serves the mean step (short run) and the variance (long run).
	assign div_start    = cmd.do_push || cmd.vdiv_start;
	assign div_long     = cmd.vdiv_start;
	assign div_dividend = cmd.vdiv_start ? m2_q : M2_W'(d_abs[SB-1:0]);
	assign div_divisor  = cmd.vdiv_start ? (count_q - 1'b1) : (count_q + 1'b1);

	wrv_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.long_run (div_long),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.quotient (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			mean_q  <= '0;
			m2_q    <= '0;
		end else begin
			if (cmd.do_clear) begin
				count_q <= '0;
				mean_q  <= '0;
				m2_q    <= '0;
			end else if (cmd.do_first) begin
				count_q <= count_q + 1'b1;
				mean_q  <= x_q;
				m2_q    <= '0;
			end else if (cmd.do_push) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.mean_upd) begin
				mean_q <= mean_sum[SB-1:0];
			end else if (cmd.acc) begin
				m2_q <= m2_sum[M2_W] ? '1 : m2_sum[M2_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q  <= action;
			x_q    <= sample[SB-1:0];
			drop_q <= 1'b0;
		end else if (cmd.set_drop) begin
			drop_q <= 1'b1;
		end
		if (cmd.do_push) begin
			d_neg_q <= d_full[SB];
			d_mag_q <= d_abs[SB-1:0];
		end
		if (cmd.mul) begin
			prod_q <= d_mag_q * e_abs[SB-1:0];
		end
	end

	assign var_val = div_quot[M2_W-1] ? VAR_MAX : div_quot[VAR_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			cnt_out_q  <= count_q;
			mean_out_q <= DATA_W'(mean_q);
			var_out_q  <= sts.cnt_gt1 ? var_val : '0;
			drop_out_q <= drop_q;
		end
	end

	assign sts.is_clear = act_q;
	assign sts.is_full  = (count_q == COUNT_MAX);
	assign sts.is_first = (count_q == '0);
	assign sts.cnt_gt1  = (count_q > CNT_W'(1));
	assign sts.div_busy = div_busy;

	assign entry_count     = cnt_out_q;
	assign running_mean    = mean_out_q;
	assign sample_variance = var_out_q;
	assign dropped         = drop_out_q;

endmodule

### rtl/wrv_checker.sv
module wrv_checker
	import wrv_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [CNT_W-1:0]  entry_count,
	input logic [DATA_W-1:0] running_mean,
	input logic [VAR_W-1:0]  sample_variance,
	input logic              dropped
);

	// A waiting result holds still until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(entry_count)
			&& $stable(running_mean) && $stable(sample_variance) && $stable(dropped))
		else $error("result changed while stalled");

	// One item at a time: an accepted item closes the input for the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted on consecutive cycles");

	// Fewer than two samples give no variance.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (entry_count < CNT_W'(2)) |-> sample_variance == '0)
		else $error("variance reported below two samples");

	// An empty accumulator reports a zero mean.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (entry_count == '0) |-> running_mean == '0)
		else $error("non-zero mean with no samples");

	// Only a full count drops a push.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dropped |-> entry_count == COUNT_MAX)
		else $error("push dropped below full count");

endmodule

bind welford_running_variance wrv_checker u_wrv_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_ready        (in_ready),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.entry_count     (entry_count),
	.running_mean    (running_mean),
	.sample_variance (sample_variance),
	.dropped         (dropped)
);

### bench/tb_welford_running_variance.sv
`timescale 1ns / 1ps

module tb_welford_running_variance;
	import wrv_pkg::*;

	// The bench and the block agree on the number of sample bits in use.
	localparam int SMP_BITS = 32;
	localparam int RANDOM_ITEMS = 1900;
	// From this item on neither side idles.
	localparam int CALM_FROM = 1700;
	// The limit allows several times what the run would take if every item were the
	// slowest one and each side idled as long as it may around it.
	localparam int CYCLE_LIMIT = 900_000;
	localparam int DRAIN_CYCLES = 120;

	localparam logic ACT_PUSH  = 1'b0;
	localparam logic ACT_CLEAR = 1'b1;

	localparam logic [DATA_W-1:0] SMP_MIN = 32'h8000_0000;
	localparam logic [DATA_W-1:0] SMP_MAX = 32'h7FFF_FFFF;

	typedef enum int {
		SMP_WIDE,
		SMP_CLUSTER,
		SMP_EDGE,
		SMP_TINY
	} smp_style_t;

	// One set of statistics as the block reports it after an item.
	typedef struct packed {
		logic [CNT_W-1:0]  count;
		logic [DATA_W-1:0] mean;
		logic [VAR_W-1:0]  variance;
		logic              dropped;
	} stats_t;

	// The scoreboard keeps its own running mean and sum of squared deviations,
	// works out the statistics that each accepted item should produce, and
	// compares each result that leaves the block with the oldest of them.
	class welford_scoreboard;
		logic [CNT_W-1:0] n_samples;
		longint           mean_q16;
		logic [M2_W-1:0]  m2_acc;
		stats_t           pending_stats[$];
		int               errors;

		function new();
			n_samples = '0;
			mean_q16 = 0;
			m2_acc = '0;
			errors = 0;
		endfunction

		function int pending_count();
			return pending_stats.size();
		endfunction

		// Updates the running statistics with one accepted item.
		function void absorb_item(logic act, logic [DATA_W-1:0] smp);
			longint            x;
			longint            dev_old;
			longint            dev_new;
			longint            step;
			logic [63:0]       mag_old;
			logic [63:0]       mag_new;
			logic [64:0]       sum;
			logic [M2_W-1:0]   quo;
			stats_t            st;

			st.dropped = 1'b0;
			if (act == ACT_CLEAR) begin
				n_samples = '0;
				mean_q16 = 0;
				m2_acc = '0;
			end else if (n_samples == COUNT_MAX) begin
				st.dropped = 1'b1;
			end else begin
				x = longint'($signed(smp << (DATA_W - SMP_BITS))) >>> (DATA_W - SMP_BITS);
				n_samples = n_samples + 1'b1;
				if (n_samples == 1) begin
					mean_q16 = x;
					m2_acc = '0;
				end else begin
					dev_old = x - mean_q16;
					// Signed division truncates towards zero.
					step = dev_old / $signed({32'b0, n_samples});
					mean_q16 = mean_q16 + step;
					dev_new = x - mean_q16;
					mag_old = (dev_old < 0) ? -dev_old : dev_old;
					mag_new = (dev_new < 0) ? -dev_new : dev_new;
					sum = {1'b0, m2_acc} + {1'b0, mag_old * mag_new};
					m2_acc = sum[64] ? '1 : sum[63:0];
				end
			end

			st.count = n_samples;
			st.mean = (n_samples != 0) ? mean_q16[DATA_W-1:0] : '0;
			if (n_samples > 1) begin
				quo = m2_acc / {32'b0, n_samples - 1'b1};
				st.variance = quo[M2_W-1] ? VAR_MAX : quo[VAR_W-1:0];
			end else begin
				st.variance = '0;
			end
			pending_stats = {pending_stats, st};
		endfunction

		// Compares one result with the oldest expectation, field by field.
		function void check_stats(logic [CNT_W-1:0] cnt, logic [DATA_W-1:0] mean,
				logic [VAR_W-1:0] variance, logic drop);
			stats_t want;

			if (pending_stats.size() == 0) begin
				$error("result with nothing expected: count %0d mean %h variance %0d dropped %0b",
					cnt, mean, variance, drop);
				errors++;
				return;
			end
			want = pending_stats.pop_front();
			if (cnt !== want.count) begin
				$error("entry_count: expected %0d, got %0d", want.count, cnt);
				errors++;
			end
			if (mean !== want.mean) begin
				$error("running_mean: expected %h, got %h", want.mean, mean);
				errors++;
			end
			if (variance !== want.variance) begin
				$error("sample_variance: expected %0d, got %0d", want.variance, variance);
				errors++;
			end
			if (drop !== want.dropped) begin
				$error("dropped: expected %0b, got %0b", want.dropped, drop);
				errors++;
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic              action;
	logic [DATA_W-1:0] sample;
	logic              out_valid;
	logic              out_ready;
	logic [CNT_W-1:0]  entry_count;
	logic [DATA_W-1:0] running_mean;
	logic [VAR_W-1:0]  sample_variance;
	logic              dropped;

	// Set once the last part of the run begins, in which nobody idles.
	logic calm_phase;
	// Set for whole sequences in which the sender never idles.
	logic eager_send;
	int   cycle_count;

	welford_scoreboard sb = new();

	welford_running_variance #(
		.SAMPLE_BITS(SMP_BITS)
	) u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.action          (action),
		.sample          (sample),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.entry_count     (entry_count),
		.running_mean    (running_mean),
		.sample_variance (sample_variance),
		.dropped         (dropped)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Both handshakes are observed at the rising edge. All inputs are driven by
	// nonblocking assignments, so the values seen here are the ones that the
	// block saw at the same edge. Input is noted before the result is checked;
	// a result leaving at the same edge always belongs to an earlier item.
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			sb.absorb_item(action, sample);
		end
		if (out_valid && out_ready) begin
			sb.check_stats(entry_count, running_mean, sample_variance, dropped);
		end
	end

	// The receiver mixes runs of readiness with stalls outside the calm phase,
	// so that a stall can land at any point of the block's work.
	initial begin
		out_ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (!calm_phase && $urandom_range(0, 2) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
		end
	end

	// A run that hangs ends here with the failure message.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("welford_running_variance: mismatch");
		$finish;
	end

	function automatic logic [DATA_W-1:0] pick_sample(smp_style_t style,
			logic [DATA_W-1:0] centre, int spread);
		case (style)
			SMP_WIDE: begin
				return $urandom;
			end
			SMP_CLUSTER: begin
				return centre + $urandom_range(0, 2 * spread) - spread;
			end
			SMP_EDGE: begin
				case ($urandom_range(0, 5))
					0: return SMP_MIN;
					1: return SMP_MAX;
					2: return '0;
					3: return '1;
					4: return SMP_MIN + $urandom_range(0, 3);
					default: return SMP_MAX - $urandom_range(0, 3);
				endcase
			end
			default: begin
				return $urandom_range(0, 64) - 32;
			end
		endcase
	endfunction

	// Presents one item and returns at the edge where it is accepted. Any idle
	// burst is taken first, with valid low, so that valid never drops once it
	// has been raised for an item.
	task automatic send_item(logic act, logic [DATA_W-1:0] smp);
		int gap;

		gap = 0;
		if (!calm_phase && !eager_send && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 16);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		sample <= smp;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic push_sample(logic [DATA_W-1:0] smp);
		send_item(ACT_PUSH, smp);
	endtask

	task automatic clear_stats();
		send_item(ACT_CLEAR, $urandom);
	endtask

	// Holds the sender back until every expected result has come out. The
	// queue is polled on the falling edge, away from the monitor's updates.
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(negedge clk); while (sb.pending_count() != 0);
		@(posedge clk);
	endtask

	initial begin
		int               sent;
		int               seq_len;
		int               spread;
		smp_style_t       style;
		logic [DATA_W-1:0] centre;

		calm_phase = 1'b0;
		eager_send = 1'b0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		action <= ACT_PUSH;
		sample <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. A clear on an empty accumulator, then a first push
		// and a second equal one, which must leave the variance at zero.
		clear_stats();
		push_sample('0);
		push_sample('0);
		// Small values whose mean step has to be truncated towards zero,
		// in both directions.
		clear_stats();
		push_sample(32'd5);
		push_sample(-32'sd4);
		push_sample(-32'sd3);
		push_sample(32'd7);
		// A single sample after a clear reports no variance.
		clear_stats();
		push_sample(SMP_MAX);
		// Alternating extremes give the largest deviations and drive the sum
		// of squared deviations into saturation within a few pushes.
		clear_stats();
		push_sample(SMP_MIN);
		push_sample(SMP_MAX);
		push_sample(SMP_MIN);
		push_sample(SMP_MAX);
		push_sample(SMP_MIN);
		push_sample(SMP_MAX);
		push_sample(SMP_MIN);
		push_sample(32'hFFFF_FFFF);
		clear_stats();
		clear_stats();
		push_sample(32'h0001_0000);
		// Saturating the sample count would take 2^32 - 1 pushes, which lies well
		// beyond a run of this length.

		// The sender waits here until the block has delivered everything.
		drain_results();

		// Random part: mostly a clear followed by a sequence of pushes drawn
		// from one style, with now and then an item of random kind mixed in.
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			calm_phase = (sent >= CALM_FROM);
			eager_send = ($urandom_range(0, 3) == 0);
			style = smp_style_t'($urandom_range(0, 3));
			centre = $urandom;
			spread = 1 << $urandom_range(0, 20);
			seq_len = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 200)
				: $urandom_range(1, 30);
			if ($urandom_range(0, 9) != 0) begin
				clear_stats();
				sent++;
			end
			for (int i = 0; i < seq_len && sent < RANDOM_ITEMS; i++) begin
				calm_phase = (sent >= CALM_FROM);
				if ($urandom_range(0, 19) == 0) begin
					send_item(1'($urandom_range(0, 1)), $urandom);
				end else begin
					push_sample(pick_sample(style, centre, spread));
				end
				sent++;
			end
			if (!calm_phase && $urandom_range(0, 14) == 0) begin
				drain_results();
			end
		end
		in_valid <= 1'b0;

		// Wait for the last results, then a little longer for any stray one.
		do @(negedge clk); while (sb.pending_count() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending_count() == 0) begin
			$display("welford_running_variance: match");
		end else begin
			$display("welford_running_variance: mismatch");
		end
		$finish;
	end

endmodule
